### hdl/sim_pkg.sv
// ----------------------------------------------------------------------------
// Sorted interval merge package
// Transaction types, operation codes and register indexes shared by the
// interval merge modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sim_pkg;

	localparam int CHROM_BITS    = 16;
	localparam int POS_BITS      = 32;
	localparam int NAME_BITS     = 16;
	localparam int COUNT_BITS    = 32;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 1;

	localparam logic OP_INTERVAL = 1'b0;
	localparam logic OP_FLUSH    = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] REG_MERGE_DISTANCE = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SAME_NAME_ONLY = 1'b1;

	typedef struct packed {
		logic                  operation;
		logic [CHROM_BITS-1:0] chrom_id;
		logic [POS_BITS-1:0]   start_pos;
		logic [POS_BITS-1:0]   stop_pos;
		logic                  has_name;
		logic [NAME_BITS-1:0]  name_id;
	} in_item_t;

	typedef struct packed {
		logic [CHROM_BITS-1:0] out_chrom;
		logic [POS_BITS-1:0]   out_start;
		logic [POS_BITS-1:0]   out_stop;
		logic [COUNT_BITS-1:0] merged_count;
		logic                  out_has_name;
		logic [NAME_BITS-1:0]  out_name;
	} out_item_t;

endpackage

`default_nettype wire

### hdl/sim_merge_core.sv
// ----------------------------------------------------------------------------
// Interval merge core
// Holds the pending merged interval and decides, for one interval or flush
// transaction, whether it joins, replaces or flushes the pending interval.
// ----------------------------------------------------------------------------
`default_nettype none

module sim_merge_core #(
	parameter int COORD_BITS = 32
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    step,
	input  sim_pkg::in_item_t                      item,
	input  wire [sim_pkg::CFG_DATA_BITS-1:0]       merge_distance,
	input  wire                                    same_name_only,
	output logic                                   emit,
	output sim_pkg::out_item_t                     result
);

	localparam int HW = (COORD_BITS < sim_pkg::POS_BITS) ? COORD_BITS : sim_pkg::POS_BITS;

	logic                             pending_q;
	logic [sim_pkg::CHROM_BITS-1:0]   chrom_q;
	logic [HW-1:0]                    start_q;
	logic [HW-1:0]                    stop_q;
	logic [sim_pkg::COUNT_BITS-1:0]   count_q;
	logic                             has_name_q;
	logic [sim_pkg::NAME_BITS-1:0]    name_q;

	logic [HW-1:0]                    start_c;
	logic [HW-1:0]                    stop_c;
	logic [HW-1:0]                    gap_c;
	logic                             near_c;
	logic                             agree_c;
	logic                             join_c;
	logic                             is_flush;

	assign is_flush = (item.operation == sim_pkg::OP_FLUSH);
	assign start_c  = item.start_pos[HW-1:0];
	assign stop_c   = item.stop_pos[HW-1:0];
	assign gap_c    = start_c - stop_q;
	assign near_c   = !((start_c > stop_q) &&
		(sim_pkg::CFG_DATA_BITS'(gap_c) > merge_distance));
	assign agree_c  = (!item.has_name && !has_name_q) ||
		(item.has_name && has_name_q && (item.name_id == name_q));
	assign join_c   = !is_flush && pending_q && (item.chrom_id == chrom_q) && near_c &&
		(!same_name_only || agree_c);
	assign emit     = pending_q && (is_flush || !join_c);

	always_comb begin
		result              = '0;
		result.out_chrom    = chrom_q;
		result.out_start    = sim_pkg::POS_BITS'(start_q);
		result.out_stop     = sim_pkg::POS_BITS'(stop_q);
		result.merged_count = count_q;
		result.out_has_name = has_name_q;
		result.out_name     = name_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (step) begin
			pending_q <= !is_flush;
		end
	end

	always_ff @(posedge clk) begin
		if (step && !is_flush) begin
			if (join_c) begin
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
				if (stop_c > stop_q) begin
					stop_q <= stop_c;
				end
			end else begin
				chrom_q    <= item.chrom_id;
				start_q    <= start_c;
				stop_q     <= stop_c;
				count_q    <= sim_pkg::COUNT_BITS'(1);
				has_name_q <= item.has_name;
				name_q     <= item.has_name ? item.name_id : '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_flush |=> !pending_q)
		else $error("flush left an interval pending");

	a_interval_pends: assert property (@(posedge clk) disable iff (!arst_n)
		step && !is_flush |=> pending_q)
		else $error("interval did not become pending");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		step && join_c |=> (count_q == (($past(count_q) == '1) ? $past(count_q) :
			$past(count_q) + 1'b1)))
		else $error("join count did not advance or saturate");

	a_stop_grows: assert property (@(posedge clk) disable iff (!arst_n)
		step && join_c |=> (stop_q >= $past(stop_q)) && (start_q == $past(start_q)))
		else $error("join shrank the pending interval");

	a_emit_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> pending_q)
		else $error("result without a pending interval");
`endif

endmodule

`default_nettype wire

### hdl/sim_out_reg.sv
// ----------------------------------------------------------------------------
// Interval merge result register
// Holds one finished merged interval until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sim_out_reg (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   load,
	input  sim_pkg::out_item_t    item,
	output logic                  free,
	output logic                  out_valid,
	input  wire                   out_stall,
	output sim_pkg::out_item_t    out_data
);

	logic               valid_q;
	sim_pkg::out_item_t data_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= item;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load && !free |=> valid_q && $stable(data_q))
		else $error("held result overwritten");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && free |=> valid_q)
		else $error("loaded result not shown");

	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_stall && !load |=> !valid_q)
		else $error("taken result shown twice");
`endif

endmodule

`default_nettype wire

### hdl/sorted_interval_merge.sv
// ----------------------------------------------------------------------------
// Sorted interval merge
// Merges a stream of sorted intervals into one pending interval and emits
// each merged interval with its join count when a non-joining interval or
// an end-of-stream flush arrives.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  in        input      in_valid/in_stall  in_data (interval or flush)
//  out       output     out_valid/out_stall out_data (merged interval)
//  cfg       input      cfg_we             cfg_index, cfg_data
//
// One transaction is accepted per cycle while the input is not stalled. The
// input register holds an accepted transaction until the merge logic takes it
// and, when it causes a result, loads that result into the result register,
// from which the result is shown and taken.
// Reset clears the pending flag, the pipeline valid bits and both configuration registers.
// The input stalls only when a result is due while the result register is
// full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_interval_merge #(
	parameter int COORD_BITS = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  sim_pkg::in_item_t                    in_data,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output sim_pkg::out_item_t                   out_data,
	input  wire                                  cfg_we,
	input  wire [sim_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire [sim_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	logic [sim_pkg::CFG_DATA_BITS-1:0] merge_distance_q;
	logic                              same_name_only_q;

	logic                valid_s1;
	sim_pkg::in_item_t   item_s1;
	logic                accept;
	logic                advance;
	logic                emit;
	logic                free;
	sim_pkg::out_item_t  result;

	assign advance  = valid_s1 && (!emit || free);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_distance_q <= '0;
			same_name_only_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				sim_pkg::REG_MERGE_DISTANCE: merge_distance_q <= cfg_data;
				sim_pkg::REG_SAME_NAME_ONLY: same_name_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	sim_merge_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.merge_distance(merge_distance_q),
		.same_name_only(same_name_only_q),
		.emit          (emit),
		.result        (result)
	);

	sim_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && emit),
		.item     (result),
		.free     (free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("waiting transaction lost");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> emit && out_valid && out_stall)
		else $error("input stalled without a blocked result");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transaction not registered");
`endif

endmodule

`default_nettype wire
